// File: hdl/sadpcm_pkg.sv
// Shared types, constants and microcode program for the subband ADPCM sample decoder.
`timescale 1ns / 1ps

package sadpcm_pkg;

    localparam int WINDOW_MAX_DEF = 32;
    localparam int CODE_W         = 8;
    localparam int SAMPLE_W       = 16;
    localparam int DIFF_W         = 24;
    localparam int ABS_W          = 24;
    localparam int STEP_W         = 16;
    localparam int SHIFT_W        = 4;
    localparam int WLEN_W         = 6;
    localparam int MINSTEP_W      = 15;
    localparam int RESCALE_SHIFT  = 15;
    localparam int STEP_LIMIT     = 65535;
    localparam int ADDR_W         = 4;
    localparam int DATA_W         = 32;
    localparam int UPC_W          = 3;

    localparam logic [SHIFT_W-1:0]   PRED_SHIFT_RST = 4'd14;
    localparam logic [SHIFT_W-1:0]   GAIN_SHIFT_RST = 4'd0;
    localparam logic [WLEN_W-1:0]    WLEN_RST       = 6'd8;
    localparam logic [MINSTEP_W-1:0] STEP_FLOOR_RST = 15'd1;

    typedef enum logic [1:0] {
        REG_PRED_SHIFT = 2'd0,
        REG_GAIN_SHIFT = 2'd1,
        REG_WINDOW_LEN = 2'd2,
        REG_STEP_FLOOR = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [SHIFT_W-1:0]   predictor_shift;
        logic [SHIFT_W-1:0]   gain_shift;
        logic [WLEN_W-1:0]    window_len;
        logic [MINSTEP_W-1:0] step_floor;
    } cfg_t;

    typedef logic [UPC_W-1:0] upc_t;

    typedef enum logic [1:0] {
        HOLD_NONE = 2'd0,
        HOLD_IN   = 2'd1,
        HOLD_OUT  = 2'd2,
        HOLD_CNT  = 2'd3
    } hold_t;

    typedef struct packed {
        logic ld_code;
        logic mul;
        logic add;
        logic emit;
        logic walk;
        logic div_init;
        logic div_step;
        logic round;
    } ctrl_t;

    typedef struct packed {
        logic cnt_nz;
        logic out_free;
    } stat_t;

    typedef struct packed {
        ctrl_t ctrl;
        hold_t hold;
        upc_t  nxt;
    } uword_t;

    localparam upc_t UA_IDLE  = 3'd0;
    localparam upc_t UA_MUL   = 3'd1;
    localparam upc_t UA_ADD   = 3'd2;
    localparam upc_t UA_EMIT  = 3'd3;
    localparam upc_t UA_WALK  = 3'd4;
    localparam upc_t UA_DINIT = 3'd5;
    localparam upc_t UA_DIV   = 3'd6;
    localparam upc_t UA_ROUND = 3'd7;

    localparam ctrl_t C_NONE = '0;

    function automatic uword_t ucode_rom(input upc_t pc);
        uword_t w;
        w.ctrl = C_NONE;
        w.hold = HOLD_NONE;
        w.nxt  = UA_IDLE;
        case (pc)
            UA_IDLE: begin
                w.ctrl.ld_code = 1'b1; w.hold = HOLD_IN;  w.nxt = UA_MUL;
            end
            UA_MUL: begin
                w.ctrl.mul = 1'b1;                        w.nxt = UA_ADD;
            end
            UA_ADD: begin
                w.ctrl.add = 1'b1;                        w.nxt = UA_EMIT;
            end
            UA_EMIT: begin
                w.ctrl.emit = 1'b1;    w.hold = HOLD_OUT; w.nxt = UA_WALK;
            end
            UA_WALK: begin
                w.ctrl.walk = 1'b1;    w.hold = HOLD_CNT; w.nxt = UA_DINIT;
            end
            UA_DINIT: begin
                w.ctrl.div_init = 1'b1;                   w.nxt = UA_DIV;
            end
            UA_DIV: begin
                w.ctrl.div_step = 1'b1; w.hold = HOLD_CNT; w.nxt = UA_ROUND;
            end
            UA_ROUND: begin
                w.ctrl.round = 1'b1;                      w.nxt = UA_IDLE;
            end
            default: begin
                w.nxt = UA_IDLE;
            end
        endcase
        return w;
    endfunction

    function automatic logic [ABS_W-1:0] abs_diff(input logic signed [DIFF_W-1:0] d);
        logic [ABS_W-1:0] r;
        r = d[DIFF_W-1] ? ABS_W'(-d) : ABS_W'(d);
        return r;
    endfunction

endpackage

// File: hdl/subband_adpcm_sample_decoder.sv
// Top level of the subband ADPCM sample decoder.
`timescale 1ns / 1ps

// One 8-bit signed code per input beat yields one 16-bit reconstructed sample per output
// beat. A microcoded sequencer runs each code through a fixed program: load the code,
// multiply, add, emit, walk the difference window memory (len - 1 reads, one per cycle,
// plus a final accumulate, where len is the effective window length), then a bit-serial
// divide of the window sum by len and a rounded step size update. A finished sample waits
// in an output register; while it is still held, the next sample stalls the program until
// the sink takes it, and the next code is taken once the current program completes.
// Configuration is to be written through the APB port only while the decoder is idle; the
// block itself does not enforce this. A step floor write takes effect at the next step
// adaptation, not on the current step size.
module subband_adpcm_sample_decoder
    import sadpcm_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [CODE_W-1:0]   s_tdata,   // [7:0] code
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [SAMPLE_W-1:0] m_tdata,   // [15:0] sample
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    cfg_t  cfg;
    ctrl_t ctrl;
    stat_t stat;

    sadpcm_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sadpcm_useq u_useq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .stat     (stat),
        .ctrl     (ctrl),
        .s_tready (s_tready)
    );

    sadpcm_dpath #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .ctrl     (ctrl),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .stat     (stat)
    );

endmodule

// File: hdl/sadpcm_regs.sv
// APB configuration register bank.
`timescale 1ns / 1ps

module sadpcm_regs
    import sadpcm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel & penable & pwrite & pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.predictor_shift <= PRED_SHIFT_RST;
            cfg_reg.gain_shift      <= GAIN_SHIFT_RST;
            cfg_reg.window_len      <= WLEN_RST;
            cfg_reg.step_floor      <= STEP_FLOOR_RST;
        end else if (wr_en) begin
            case (idx)
                REG_PRED_SHIFT: cfg_reg.predictor_shift <= pwdata[SHIFT_W-1:0];
                REG_GAIN_SHIFT: cfg_reg.gain_shift      <= pwdata[SHIFT_W-1:0];
                REG_WINDOW_LEN: cfg_reg.window_len      <= pwdata[WLEN_W-1:0];
                REG_STEP_FLOOR: cfg_reg.step_floor      <= pwdata[MINSTEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_PRED_SHIFT: prdata = DATA_W'(cfg_reg.predictor_shift);
            REG_GAIN_SHIFT: prdata = DATA_W'(cfg_reg.gain_shift);
            REG_WINDOW_LEN: prdata = DATA_W'(cfg_reg.window_len);
            REG_STEP_FLOOR: prdata = DATA_W'(cfg_reg.step_floor);
            default:        prdata = '0;
        endcase
    end

endmodule

// File: hdl/sadpcm_useq.sv
// Microcode sequencer: step counter, control store and hold conditions.
`timescale 1ns / 1ps

module sadpcm_useq
    import sadpcm_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    input  stat_t stat,
    output ctrl_t ctrl,
    output logic  s_tready
);

    upc_t   pc_reg;
    upc_t   pc_next;
    uword_t word;
    logic   hold_active;

    assign word     = ucode_rom(pc_reg);
    assign ctrl     = word.ctrl;
    assign s_tready = word.ctrl.ld_code & aresetn;

    always_comb begin
        case (word.hold)
            HOLD_IN:  hold_active = ~s_tvalid;
            HOLD_OUT: hold_active = ~stat.out_free;
            HOLD_CNT: hold_active = stat.cnt_nz;
            default:  hold_active = 1'b0;
        endcase
        pc_next = hold_active ? pc_reg : word.nxt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= UA_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

// File: hdl/sadpcm_dpath.sv
// Datapath: reconstruction, predictor, difference window, serial divider and step update.
`timescale 1ns / 1ps

module sadpcm_dpath
    import sadpcm_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  ctrl_t               ctrl,
    input  logic                s_tvalid,
    input  logic [CODE_W-1:0]   s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [SAMPLE_W-1:0] m_tdata,
    output stat_t               stat
);

    localparam int PTR_W  = $clog2(WINDOW_MAX);
    localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W  = ABS_W + $clog2(WINDOW_MAX);
    localparam int DIVD_W = SUM_W + (2 ** SHIFT_W) - 1;
    localparam int CNT_W  = $clog2(DIVD_W + WINDOW_MAX);
    localparam int Q_W    = DIVD_W + 1 - RESCALE_SHIFT;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_MAX - 1);

    logic signed [DIFF_W-1:0]   mem [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]      valid_reg;

    logic signed [CODE_W-1:0]   code_reg;
    logic signed [DIFF_W-1:0]   diff_reg;
    logic [SAMPLE_W-1:0]        sample_reg;
    logic [SAMPLE_W-1:0]        pred_reg;
    logic [STEP_W-1:0]          step_reg;
    logic [PTR_W-1:0]           wr_pos_reg;
    logic [PTR_W-1:0]           rd_ptr_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [LEN_W-1:0]           len_reg;
    logic [SUM_W-1:0]           acc_reg;
    logic [DIVD_W-1:0]          dvd_reg;
    logic [LEN_W-1:0]           rem_reg;
    logic signed [DIFF_W-1:0]   rd_data_reg;
    logic                       rd_vld_reg;
    logic                       rd_pend_reg;
    logic [SAMPLE_W-1:0]        out_reg;
    logic                       out_valid_reg;

    logic                       out_free;
    logic                       rd_en;
    logic [LEN_W-1:0]           len_eff;
    logic signed [DIFF_W:0]     prod;
    logic signed [31:0]         pred_ext;
    logic signed [31:0]         pred_shl;
    logic signed [31:0]         pred_rnd;
    logic [LEN_W:0]             rem_sh;
    logic                       q_bit;
    logic [DIVD_W:0]            rnd_sum;
    logic [Q_W-1:0]             rnd_q;
    logic [STEP_W-1:0]          step_sat;
    logic [STEP_W-1:0]          step_next;
    logic [ABS_W-1:0]           rd_abs;

    assign out_free      = ~out_valid_reg | m_tready;
    assign stat.out_free = out_free;
    assign stat.cnt_nz   = (cnt_reg != '0);
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = out_reg;
    assign rd_en         = ctrl.walk & (cnt_reg != '0);

    always_comb begin
        if (cfg.window_len == '0) begin
            len_eff = LEN_W'(1);
        end else if (32'(cfg.window_len) > WINDOW_MAX) begin
            len_eff = LEN_W'(WINDOW_MAX);
        end else begin
            len_eff = LEN_W'(cfg.window_len);
        end
    end

    assign prod = $signed({1'b0, step_reg}) * code_reg;

    always_comb begin
        pred_ext = {{(32 - SAMPLE_W){sample_reg[SAMPLE_W-1]}}, sample_reg};
        pred_shl = pred_ext <<< cfg.predictor_shift;
        pred_rnd = pred_shl + 32'sd16384;
    end

    assign rem_sh = {rem_reg, dvd_reg[DIVD_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, len_reg});
    assign rd_abs = rd_vld_reg ? abs_diff(rd_data_reg) : '0;

    always_comb begin
        rnd_sum = {1'b0, dvd_reg} + (DIVD_W + 1)'(2 ** (RESCALE_SHIFT - 1));
        rnd_q   = rnd_sum[DIVD_W:RESCALE_SHIFT];
        if (rnd_q > Q_W'(STEP_LIMIT)) begin
            step_sat = STEP_W'(STEP_LIMIT);
        end else begin
            step_sat = rnd_q[STEP_W-1:0];
        end
        if (step_sat < {1'b0, cfg.step_floor}) begin
            step_next = {1'b0, cfg.step_floor};
        end else begin
            step_next = step_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.add) begin
            mem[wr_pos_reg] <= diff_reg;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ld_code & s_tvalid) begin
            code_reg <= s_tdata;
        end
        if (ctrl.mul) begin
            diff_reg <= prod[DIFF_W-1:0];
        end
        if (ctrl.add) begin
            sample_reg <= diff_reg[SAMPLE_W-1:0] + pred_reg;
            len_reg    <= len_eff;
            rd_ptr_reg <= (wr_pos_reg == '0) ? PTR_LAST : wr_pos_reg - PTR_W'(1);
            acc_reg    <= SUM_W'(abs_diff(diff_reg));
        end
        if (ctrl.emit & out_free) begin
            out_reg <= sample_reg;
        end
        if (ctrl.walk) begin
            if (rd_pend_reg) begin
                acc_reg <= acc_reg + SUM_W'(rd_abs);
            end
            if (rd_en) begin
                rd_ptr_reg <= (rd_ptr_reg == '0) ? PTR_LAST : rd_ptr_reg - PTR_W'(1);
            end
        end
        if (ctrl.div_init) begin
            dvd_reg <= DIVD_W'(acc_reg) << cfg.gain_shift;
            rem_reg <= '0;
        end
        if (ctrl.div_step) begin
            rem_reg <= q_bit ? LEN_W'(rem_sh - {1'b0, len_reg}) : rem_sh[LEN_W-1:0];
            dvd_reg <= {dvd_reg[DIVD_W-2:0], q_bit};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            wr_pos_reg    <= '0;
            pred_reg      <= '0;
            step_reg      <= STEP_W'(STEP_FLOOR_RST);
            cnt_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (ctrl.add) begin
                valid_reg[wr_pos_reg] <= 1'b1;
                wr_pos_reg <= (wr_pos_reg == PTR_LAST) ? '0 : wr_pos_reg + PTR_W'(1);
                cnt_reg    <= CNT_W'(len_eff - LEN_W'(1));
            end
            if (ctrl.emit & out_free) begin
                pred_reg <= pred_rnd[30:15];
            end
            if (ctrl.walk) begin
                rd_pend_reg <= rd_en;
                if (rd_en) begin
                    rd_vld_reg <= valid_reg[rd_ptr_reg];
                end
            end
            if ((ctrl.walk | ctrl.div_step) && cnt_reg != '0) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            if (ctrl.div_init) begin
                cnt_reg <= CNT_W'(DIVD_W - 1);
            end
            if (ctrl.round) begin
                step_reg <= step_next;
            end
            if (ctrl.emit & out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
